// ===== rtl/multiversion_value_store_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multiversion value store
// Shorthands for clocked assertions with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef MULTIVERSION_VALUE_STORE_CORE_ASSERT_SVH
`define MULTIVERSION_VALUE_STORE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MVS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mvs_pkg.sv =====
// ----------------------------------------------------------------------------
// Multiversion value store package
// Sizes, action codes, the request token that walks the cell row, and
// payload helpers.
// ----------------------------------------------------------------------------
package mvs_pkg;

	localparam int MAX_VERSIONS = 8;
	localparam int VALUE_BYTES  = 8;

	localparam int VER_W  = 32;
	localparam int DATA_W = 64;
	localparam int LEN_W  = 4;
	localparam int CNT_OUT_W = 4;
	localparam int CNT_W  = $clog2(MAX_VERSIONS + 1);

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERSIONS);

	localparam logic ACT_ADD = 1'b0;
	localparam logic ACT_GET = 1'b1;

	// Request token handed from cell to cell.
	typedef struct packed {
		logic              vld;
		logic              active;
		logic              act;
		logic              found;
		logic              ovw;
		logic [VER_W-1:0]  ver;
		logic [DATA_W-1:0] data;
		logic [LEN_W-1:0]  len;
	} tok_t;

	// Position of a cell relative to the live part of the list.
	typedef struct packed {
		logic live;
		logic tail;
	} cell_ctl_t;

	function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] n);
		if (n > LEN_W'(VALUE_BYTES)) begin
			return LEN_W'(VALUE_BYTES);
		end
		return n;
	endfunction

	function automatic logic [DATA_W-1:0] mask_payload(input logic [DATA_W-1:0] d,
		input logic [LEN_W-1:0] n);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int b = 0; b < DATA_W / 8; b++) begin
			if (b < int'(n)) begin
				m[b*8 +: 8] = 8'hFF;
			end
		end
		return d & m;
	endfunction

endpackage

// ===== rtl/mvs_if.sv =====
// ----------------------------------------------------------------------------
// Multiversion value store channel interfaces
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface mvs_req_if;
	import mvs_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     action;
	logic signed [VER_W-1:0]  version_key;
	logic [DATA_W-1:0]        value_data;
	logic [LEN_W-1:0]         value_length;

	modport source (output valid, action, version_key, value_data, value_length,
		input ready);
	modport sink (input valid, action, version_key, value_data, value_length,
		output ready);
endinterface

interface mvs_rsp_if;
	import mvs_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     found;
	logic signed [VER_W-1:0]  out_version;
	logic [DATA_W-1:0]        out_data;
	logic [LEN_W-1:0]         out_length;
	logic [CNT_OUT_W-1:0]     entry_count;

	modport source (output valid, found, out_version, out_data, out_length, entry_count,
		input ready);
	modport sink (input valid, found, out_version, out_data, out_length, entry_count,
		output ready);
endinterface

// ===== rtl/multiversion_value_store_core.sv =====
// ----------------------------------------------------------------------------
// Multiversion value store core
// Bounded list of versioned payloads, newest first, with add and get requests.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake    Carries
//   req      in         valid/ready  action, version_key, value_data, value_length
//   rsp      out        valid/ready  found, out_version, out_data, out_length,
//                                    entry_count
//
// One request is in flight at a time. It is latched into an entry register and
// then walks the row of MAX_VERSIONS cells, one cell per cycle while the row is
// not stalled; the next request is accepted only once the current one has left
// the row.
// Reset clears the entry count and all handshake and token flags; the cell
// contents are left as they are, since only cells below the count are read.
// If the response register is still full when the token reaches the end of
// the row, the whole row holds until the response is taken.
//
module multiversion_value_store_core (
	input logic   clk,
	input logic   arst_n,
	mvs_req_if.sink   req,
	mvs_rsp_if.source rsp
);
	import mvs_pkg::*;

	`include "multiversion_value_store_core_assert.svh"

	// Token positions: index 0 is the entry register, index i+1 the output of
	// cell i. The last position is where a finished request leaves the row.
	tok_t              chain_tok [0:MAX_VERSIONS];
	logic [MAX_VERSIONS:0] tok_vld;
	tok_t              entry_q;
	tok_t              last_tok;

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  base_q;
	logic [CNT_W-1:0]  cnt_nxt;
	logic              accept;
	logic              exit_row;
	logic              en;

	logic                 rsp_vld_q;
	logic                 found_q;
	logic [VER_W-1:0]     ver_q;
	logic [DATA_W-1:0]    data_q;
	logic [LEN_W-1:0]     len_q;
	logic [CNT_OUT_W-1:0] cnt_out_q;

	logic [LEN_W-1:0]  in_len;

	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;

	assign chain_tok[0] = entry_q;
	assign last_tok     = chain_tok[MAX_VERSIONS];

	// The finished request leaves the row when the response register is free
	// or is being emptied in this cycle; otherwise the row stalls.
	assign exit_row = last_tok.vld && (!rsp_vld_q || rsp.ready);
	assign en       = !(last_tok.vld && !exit_row);

	// An add that overwrote an equal version leaves the count at its base;
	// any other add places one new entry at the tail of the live part.
	assign cnt_nxt = (last_tok.act == ACT_ADD && !last_tok.ovw) ?
		base_q + CNT_W'(1) : base_q;

	assign in_len = sat_len(req.value_length);

	for (genvar i = 0; i < MAX_VERSIONS; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		cell_ctl_t ctl;

		assign ctl.live = IDX < base_q;
		assign ctl.tail = IDX == base_q;

		mvs_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl     (ctl),
			.tok_in  (chain_tok[i]),
			.tok_out (chain_tok[i+1])
		);
	end

	for (genvar i = 0; i <= MAX_VERSIONS; i++) begin : g_vld
		assign tok_vld[i] = chain_tok[i].vld;
	end

	// Entry register and item bookkeeping. A full store drops its oldest
	// entry before the add walks the row, even if the add later overwrites.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			base_q  <= '0;
		end else begin
			if (accept) begin
				entry_q.vld    <= 1'b1;
				entry_q.active <= 1'b1;
				entry_q.act    <= req.action;
				entry_q.found  <= 1'b0;
				entry_q.ovw    <= 1'b0;
				entry_q.ver    <= req.version_key;
				entry_q.data   <= mask_payload(req.value_data, in_len);
				entry_q.len    <= in_len;
				busy_q         <= 1'b1;
				base_q         <= (req.action == ACT_ADD && cnt_q == MAX_CNT) ?
					MAX_CNT - CNT_W'(1) : cnt_q;
			end else if (en) begin
				entry_q.vld <= 1'b0;
			end
			if (exit_row) begin
				busy_q <= 1'b0;
				cnt_q  <= cnt_nxt;
			end
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (exit_row) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	// A get that missed and every add report zeros in the entry fields.
	always_ff @(posedge clk) begin
		if (exit_row) begin
			found_q   <= (last_tok.act == ACT_GET) && last_tok.found;
			ver_q     <= (last_tok.act == ACT_GET && last_tok.found) ? last_tok.ver : '0;
			data_q    <= (last_tok.act == ACT_GET && last_tok.found) ? last_tok.data : '0;
			len_q     <= (last_tok.act == ACT_GET && last_tok.found) ? last_tok.len : '0;
			cnt_out_q <= CNT_OUT_W'(cnt_nxt);
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.found       = found_q;
	assign rsp.out_version = ver_q;
	assign rsp.out_data    = data_q;
	assign rsp.out_length  = len_q;
	assign rsp.entry_count = cnt_out_q;

	// The list never holds more entries than it has cells.
	`MVS_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= MAX_CNT, "count above capacity")
	// Only one request token is ever in the entry register and the row.
	`MVS_ASSERT_NOW(a_one_token, clk, arst_n, 1'b1, $countones(tok_vld) <= 1, "two tokens in row")
	// Every add has found a cell by the time it leaves the row.
	`MVS_ASSERT_NOW(a_add_placed, clk, arst_n, last_tok.vld && last_tok.act == ACT_ADD, !last_tok.active, "add left the row unplaced")
	// The count only changes when a request leaves the row.
	`MVS_ASSERT_NEXT(a_cnt_hold, clk, arst_n, !exit_row, $stable(cnt_q), "count changed mid request")

endmodule

// ===== rtl/mvs_cell.sv =====
// ----------------------------------------------------------------------------
// Multiversion value store cell
// Holds one list entry and processes the request token passing through it.
// ----------------------------------------------------------------------------
module mvs_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  mvs_pkg::cell_ctl_t ctl,
	input  mvs_pkg::tok_t      tok_in,
	output mvs_pkg::tok_t      tok_out
);
	import mvs_pkg::*;

	logic [VER_W-1:0]  ver_q;
	logic [DATA_W-1:0] data_q;
	logic [LEN_W-1:0]  len_q;
	tok_t              tok_out_q;
	tok_t              tok_nxt;
	logic              wr;

	// An add swaps itself in ahead of an older entry and carries the older one
	// on, so the row shifts by one as the token walks down.
	always_comb begin
		tok_nxt = tok_in;
		wr      = 1'b0;
		if (tok_in.vld && tok_in.active) begin
			if (tok_in.act == ACT_ADD) begin
				if (ctl.live) begin
					if ($signed(tok_in.ver) > $signed(ver_q)) begin
						wr           = 1'b1;
						tok_nxt.ver  = ver_q;
						tok_nxt.data = data_q;
						tok_nxt.len  = len_q;
					end else if (tok_in.ver == ver_q) begin
						wr             = 1'b1;
						tok_nxt.active = 1'b0;
						tok_nxt.ovw    = 1'b1;
					end
				end else if (ctl.tail) begin
					wr             = 1'b1;
					tok_nxt.active = 1'b0;
				end
			end else if (ctl.live && ($signed(ver_q) <= $signed(tok_in.ver))) begin
				tok_nxt.active = 1'b0;
				tok_nxt.found  = 1'b1;
				tok_nxt.ver    = ver_q;
				tok_nxt.data   = data_q;
				tok_nxt.len    = len_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out_q <= '0;
		end else if (en) begin
			tok_out_q <= tok_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (en && wr) begin
			ver_q  <= tok_in.ver;
			data_q <= tok_in.data;
			len_q  <= tok_in.len;
		end
	end

	assign tok_out = tok_out_q;

endmodule

// ===== bench/tb_multiversion_value_store_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the multiversion value store core
// Sends add and get requests through the request channel and checks every
// response against a local model of the newest-first version list, or against a
// hand-written result for typed directed rows. Both channels stall at random, and
// the response side holds off once for a long stretch so that the block backs up
// into its request channel.
module tb_multiversion_value_store_core;
	import mvs_pkg::*;

	localparam logic signed [VER_W-1:0] VER_TOP    = 32'sh7FFF_FFFF;
	localparam logic signed [VER_W-1:0] VER_BOTTOM = 32'sh8000_0000;
	localparam logic [DATA_W-1:0]       ALL_ONES   = {DATA_W{1'b1}};
	localparam int RANDOM_REQUESTS = 1275;
	localparam int BUSY_CYCLES     = MAX_VERSIONS + 2;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int HOLD_OFF_AFTER  = 300;

	// What one response is expected to carry.
	typedef struct {
		logic                    found;
		logic signed [VER_W-1:0] ver;
		logic [DATA_W-1:0]       data;
		logic [LEN_W-1:0]        len;
		logic [CNT_OUT_W-1:0]    count;
	} store_result_t;

	// One line of the directed table. Where typed is set, the response is
	// written out by hand rather than taken from the list model.
	typedef struct {
		logic                    act;
		logic signed [VER_W-1:0] key;
		logic [DATA_W-1:0]       data;
		logic [LEN_W-1:0]        len;
		bit                      typed;
		store_result_t           want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	mvs_req_if req ();
	mvs_rsp_if rsp ();

	multiversion_value_store_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Local copy of the version list, newest first; only the first
	// list_count entries are meaningful.
	logic signed [VER_W-1:0] list_ver  [MAX_VERSIONS];
	logic [DATA_W-1:0]       list_data [MAX_VERSIONS];
	logic [LEN_W-1:0]        list_len  [MAX_VERSIONS];
	int                      list_count;

	store_result_t pending_results[$];
	stim_row_t     directed_rows[$];
	int            failures;
	int            responses_seen;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Applies one request to the list model and returns the response it
	// should produce.
	function automatic store_result_t version_list_step(input logic act,
		input logic signed [VER_W-1:0] key, input logic [DATA_W-1:0] data,
		input logic [LEN_W-1:0] len);
		store_result_t r;
		logic [LEN_W-1:0] n;
		logic [DATA_W-1:0] keep;
		int pos;
		bit hit;
		r = '{found: 1'b0, ver: '0, data: '0, len: '0, count: '0};
		if (act == ACT_ADD) begin
			// Lengths past the payload width saturate, and bytes past the
			// length are stored as zero.
			n = (len > LEN_W'(VALUE_BYTES)) ? LEN_W'(VALUE_BYTES) : len;
			keep = (n >= 4'd8) ? ALL_ONES : ((64'd1 << (8 * n)) - 64'd1);
			// A full list always drops its oldest entry first, even when the
			// new version then turns out to overwrite an existing one.
			if (list_count >= MAX_VERSIONS) begin
				list_count = MAX_VERSIONS - 1;
			end
			pos = list_count;
			hit = 1'b0;
			for (int i = 0; i < list_count; i++) begin
				if (key > list_ver[i]) begin
					pos = i;
					break;
				end
				if (key == list_ver[i]) begin
					pos = i;
					hit = 1'b1;
					break;
				end
			end
			if (!hit) begin
				for (int j = list_count; j > pos; j--) begin
					list_ver[j]  = list_ver[j-1];
					list_data[j] = list_data[j-1];
					list_len[j]  = list_len[j-1];
				end
				list_count++;
			end
			list_ver[pos]  = key;
			list_data[pos] = data & keep;
			list_len[pos]  = n;
		end else begin
			// The first entry at or below the bound is the newest such one.
			for (int i = 0; i < list_count; i++) begin
				if (list_ver[i] <= key) begin
					r.found = 1'b1;
					r.ver   = list_ver[i];
					r.data  = list_data[i];
					r.len   = list_len[i];
					break;
				end
			end
		end
		r.count = CNT_OUT_W'(list_count);
		return r;
	endfunction

	// Mostly back to back or short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 88) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Versions cluster in a narrow window so that overwrites, evictions and
	// hits are common; the rest are spread over the whole range and its ends.
	function automatic logic signed [VER_W-1:0] pick_version(
		input logic signed [VER_W-1:0] base);
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			return base + $urandom_range(0, 24);
		end else if (r < 8) begin
			return $urandom;
		end else if (r == 8) begin
			return $urandom_range(0, 1) ? VER_TOP - $urandom_range(0, 3) :
				VER_BOTTOM + $urandom_range(0, 3);
		end
		return base - $urandom_range(1, 30);
	endfunction

	task automatic table_row(input logic act, input logic signed [VER_W-1:0] key,
		input logic [DATA_W-1:0] data, input logic [LEN_W-1:0] len, input bit typed,
		input logic found, input logic signed [VER_W-1:0] over,
		input logic [DATA_W-1:0] odata, input logic [LEN_W-1:0] olen,
		input logic [CNT_OUT_W-1:0] cnt);
		stim_row_t row;
		row.act   = act;
		row.key   = key;
		row.data  = data;
		row.len   = len;
		row.typed = typed;
		row.want  = '{found: found, ver: over, data: odata, len: olen, count: cnt};
		directed_rows.push_back(row);
	endtask

	// Offers one request after an optional idle gap and waits until the block
	// takes it. Valid is only lowered when a gap follows, so a request that
	// comes straight after the previous one keeps valid high.
	task automatic offer_request(input logic act, input logic signed [VER_W-1:0] key,
		input logic [DATA_W-1:0] data, input logic [LEN_W-1:0] len, input bit typed,
		input store_result_t want, input int gap);
		store_result_t predicted;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid        <= 1'b1;
		req.action       <= act;
		req.version_key  <= key;
		req.value_data   <= data;
		req.value_length <= len;
		do @(posedge clk); while (!req.ready);
		predicted = version_list_step(act, key, data, len);
		if (typed) begin
			pending_results.push_back(want);
		end else begin
			pending_results.push_back(predicted);
		end
	endtask

	// Request side: reset, the directed table, then random traffic.
	initial begin
		logic signed [VER_W-1:0] base;
		logic [LEN_W-1:0] len;
		stim_row_t row;
		int gap;
		arst_n            <= 1'b0;
		req.valid         <= 1'b0;
		req.action        <= ACT_ADD;
		req.version_key   <= '0;
		req.value_data    <= '0;
		req.value_length  <= '0;
		list_count = 0;

		// An empty list misses, and the first add counts one entry.
		table_row(ACT_GET, 32'sd0, 64'h0, 4'd0, 1'b1, 1'b0, 32'sd0, 64'h0, 4'd0, 4'd0);
		table_row(ACT_ADD, VER_BOTTOM, ALL_ONES, 4'd8, 1'b1, 1'b0, 32'sd0, 64'h0, 4'd0,
			4'd1);
		table_row(ACT_GET, VER_TOP, ALL_ONES, 4'd15, 1'b1, 1'b1, VER_BOTTOM, ALL_ONES, 4'd8,
			4'd1);
		// An over-long length saturates to the full payload.
		table_row(ACT_ADD, VER_TOP, 64'h0123_4567_89AB_CDEF, 4'd15, 1'b1, 1'b0, 32'sd0,
			64'h0, 4'd0, 4'd2);
		table_row(ACT_GET, VER_TOP, 64'h0, 4'd0, 1'b1, 1'b1, VER_TOP,
			64'h0123_4567_89AB_CDEF, 4'd8, 4'd2);
		table_row(ACT_GET, VER_TOP - 32'sd1, 64'h0, 4'd0, 1'b1, 1'b1, VER_BOTTOM, ALL_ONES,
			4'd8, 4'd2);
		// Bytes past the length are stored as zero.
		table_row(ACT_ADD, 32'sd0, ALL_ONES, 4'd3, 1'b1, 1'b0, 32'sd0, 64'h0, 4'd0, 4'd3);
		table_row(ACT_GET, 32'sd0, 64'h0, 4'd0, 1'b1, 1'b1, 32'sd0, 64'h00FF_FFFF, 4'd3,
			4'd3);
		// Overwriting an equal version keeps the count; an empty payload is
		// still an entry and is found by a get.
		table_row(ACT_ADD, 32'sd0, 64'hDEAD_BEEF_CAFE_F00D, 4'd0, 1'b1, 1'b0, 32'sd0, 64'h0,
			4'd0, 4'd3);
		table_row(ACT_GET, 32'sd5, 64'h0, 4'd0, 1'b1, 1'b1, 32'sd0, 64'h0, 4'd0, 4'd3);
		table_row(ACT_GET, -32'sd1, 64'h0, 4'd0, 1'b1, 1'b1, VER_BOTTOM, ALL_ONES, 4'd8,
			4'd3);
		// Fill the list.
		table_row(ACT_ADD, 32'sd100, 64'h1111_1111_1111_1111, 4'd1, 1'b1, 1'b0, 32'sd0,
			64'h0, 4'd0, 4'd4);
		table_row(ACT_ADD, 32'sd200, 64'h2222_2222_2222_2222, 4'd2, 1'b1, 1'b0, 32'sd0,
			64'h0, 4'd0, 4'd5);
		table_row(ACT_ADD, 32'sd300, 64'h3333_3333_3333_3333, 4'd4, 1'b1, 1'b0, 32'sd0,
			64'h0, 4'd0, 4'd6);
		table_row(ACT_ADD, 32'sd400, 64'h4444_4444_4444_4444, 4'd7, 1'b1, 1'b0, 32'sd0,
			64'h0, 4'd0, 4'd7);
		table_row(ACT_ADD, 32'sd500, 64'h5555_5555_5555_5555, 4'd8, 1'b1, 1'b0, 32'sd0,
			64'h0, 4'd0, 4'd8);
		// A new version on a full list evicts the oldest and stays full.
		table_row(ACT_ADD, 32'sd600, 64'h6666_6666_6666_6666, 4'd5, 1'b1, 1'b0, 32'sd0,
			64'h0, 4'd0, 4'd8);
		// An equal version on a full list still evicts, so the count drops.
		table_row(ACT_ADD, 32'sd300, 64'h7777_7777_7777_7777, 4'd6, 1'b1, 1'b0, 32'sd0,
			64'h0, 4'd0, 4'd7);
		table_row(ACT_GET, -32'sd1, 64'h0, 4'd0, 1'b1, 1'b0, 32'sd0, 64'h0, 4'd0, 4'd7);
		table_row(ACT_GET, 32'sd250, 64'h0, 4'd0, 1'b0, 1'b0, 32'sd0, 64'h0, 4'd0, 4'd0);
		table_row(ACT_GET, 32'sd300, 64'h0, 4'd0, 1'b0, 1'b0, 32'sd0, 64'h0, 4'd0, 4'd0);
		table_row(ACT_ADD, -32'sd5, 64'h8899_AABB_CCDD_EEFF, 4'd9, 1'b0, 1'b0, 32'sd0,
			64'h0, 4'd0, 4'd0);
		table_row(ACT_GET, VER_BOTTOM, 64'h0, 4'd0, 1'b1, 1'b0, 32'sd0, 64'h0, 4'd0, 4'd8);
		// Equal to the oldest on a full list: it is evicted, then re-added.
		table_row(ACT_ADD, -32'sd5, 64'h0F0F_0F0F_0F0F_0F0F, 4'd6, 1'b0, 1'b0, 32'sd0,
			64'h0, 4'd0, 4'd0);
		table_row(ACT_GET, -32'sd5, 64'h0, 4'd0, 1'b0, 1'b0, 32'sd0, 64'h0, 4'd0, 4'd0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			row = directed_rows[k];
			offer_request(row.act, row.key, row.data, row.len, row.typed, row.want,
				pick_gap());
		end

		base = 32'sd0;
		for (int k = 0; k < RANDOM_REQUESTS; k++) begin
			// Move the version window now and then, often near the ends of
			// the range so that the signed ordering is exercised.
			if (k % 100 == 0) begin
				case ($urandom_range(0, 3))
					0: base = $urandom;
					1: base = VER_TOP - $urandom_range(0, 40);
					2: base = VER_BOTTOM + $urandom_range(0, 40);
					default: base = $urandom_range(0, 200) - 100;
				endcase
			end
			len = ($urandom_range(0, 9) < 8) ? LEN_W'($urandom_range(0, 8)) :
				LEN_W'($urandom_range(9, 15));
			// Every 200 requests, a run of 30 goes out back to back.
			gap = (k % 200 < 30) ? 0 : pick_gap();
			offer_request($urandom_range(0, 1) ? ACT_GET : ACT_ADD, pick_version(base),
				{$urandom, $urandom}, len, 1'b0, '{1'b0, '0, '0, '0, '0}, gap);
		end
		req.valid <= 1'b0;

		wait (pending_results.size() == 0);
		repeat (4 * BUSY_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Response side: random stalls, occasional long open stretches, and one
	// long hold-off that lets the block back up into the request channel.
	initial begin
		bit held_off;
		int gap;
		held_off = 1'b0;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!held_off && responses_seen >= HOLD_OFF_AFTER) begin
				held_off = 1'b1;
				rsp.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			repeat (($urandom_range(0, 19) == 0) ? $urandom_range(50, 150) :
				$urandom_range(1, 6)) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Response checker: each accepted response is matched against the
	// oldest outstanding expectation.
	always @(posedge clk) begin
		store_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			responses_seen++;
			if (pending_results.size() == 0) begin
				$error("response with no request outstanding");
				failures++;
			end else begin
				want = pending_results.pop_front();
				if (rsp.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, rsp.found);
					failures++;
				end
				if (rsp.out_version !== want.ver) begin
					$error("out_version: expected %0d, got %0d", want.ver, rsp.out_version);
					failures++;
				end
				if (rsp.out_data !== want.data) begin
					$error("out_data: expected %h, got %h", want.data, rsp.out_data);
					failures++;
				end
				if (rsp.out_length !== want.len) begin
					$error("out_length: expected %0d, got %0d", want.len, rsp.out_length);
					failures++;
				end
				if (rsp.entry_count !== want.count) begin
					$error("entry_count: expected %0d, got %0d", want.count,
						rsp.entry_count);
					failures++;
				end
			end
		end
	end

	initial begin
		failures = 0;
		responses_seen = 0;
	end

	// Watchdog, well beyond the slowest legal run.
	initial begin
		#40_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mvs_pkg.sv
rtl/mvs_if.sv
rtl/mvs_cell.sv
rtl/multiversion_value_store_core.sv
bench/tb_multiversion_value_store_core.sv
